// ----- rtl/int32_to_float32_converter_defines.svh -----
// Assertion macros for the integer to single-precision converter.
`ifndef INT32_TO_FLOAT32_CONVERTER_DEFINES_SVH
`define INT32_TO_FLOAT32_CONVERTER_DEFINES_SVH
`ifndef SYNTH
// Check a property while out of reset.
`define I2F_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("i2f check failed");
// Check a property at every edge, reset included.
`define I2F_ASSERT_ALWAYS(label, prop) \
	label: assert property (@(posedge clk) prop) \
	else $error("i2f check failed");
`else
`define I2F_ASSERT(label, prop)
`define I2F_ASSERT_ALWAYS(label, prop)
`endif
`endif

// ----- rtl/i2f_pkg.sv -----
// Constants, types and helper functions for the integer to float converter.
package i2f_pkg;

	localparam int IntWidth  = 32;
	localparam int FracBits  = 23;
	localparam int ExpWidth  = 8;
	localparam int LeadWidth = 5;

	localparam logic [ExpWidth-1:0] ExpBias = 8'd127;

	typedef logic [IntWidth-1:0]  word_t;
	typedef logic [LeadWidth-1:0] lead_t;
	typedef logic [ExpWidth-1:0]  exp_t;
	typedef logic [FracBits-1:0]  frac_t;

	// Return the position of the highest set bit (zero for a zero word).
	function automatic lead_t find_lead(input word_t m);
		lead_t pos;
		pos = '0;
		for (int i = 0; i < IntWidth; i++) begin
			if (m[i]) begin
				pos = lead_t'(i);
			end
		end
		return pos;
	endfunction

endpackage

// ----- rtl/int32_to_float32_converter.sv -----
// Throughput: one transaction per cycle; stages advance only where the next is free.
// Stages: magnitude, leading-one search, normalizing shift, round and pack.
// Reset: arst_n clears all stage valid bits at once; payload registers are not reset.
// No state persists between transactions, so reset only empties the pipeline.
// Signed 32-bit integer to IEEE 754 single precision, round to nearest even.
`include "int32_to_float32_converter_defines.svh"

module int32_to_float32_converter (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic signed [31:0]  int_value,
	output logic                out_valid,
	input  logic                out_ready,
	output logic        [31:0]  float_bits
);

	// Stage valid bits and per-stage advance enables
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	// Stage payloads
	logic               neg_s1;
	i2f_pkg::word_t     mag_s1;
	logic               neg_s2;
	logic               zero_s2;
	i2f_pkg::word_t     mag_s2;
	i2f_pkg::lead_t     lead_s2;
	logic               neg_s3;
	logic               zero_s3;
	i2f_pkg::word_t     norm_s3;
	i2f_pkg::exp_t      exp_s3;
	i2f_pkg::word_t     res_s4;

	// Rounding logic between stage 3 and stage 4
	logic [i2f_pkg::FracBits:0]   sig;
	logic                         guard_bit;
	logic                         sticky_bit;
	logic                         round_up;
	logic [i2f_pkg::FracBits+1:0] sig_sum;
	i2f_pkg::exp_t                exp_fin;
	i2f_pkg::frac_t               frac_fin;
	i2f_pkg::word_t               res_next;

	// Let a stage take new data when it is empty or its content moves on
	assign rdy_s4   = !v_s4 || out_ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Advance valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				v_s1 <= in_valid;
			end
			if (rdy_s2) begin
				v_s2 <= v_s1;
			end
			if (rdy_s3) begin
				v_s3 <= v_s2;
			end
			if (rdy_s4) begin
				v_s4 <= v_s3;
			end
		end
	end

	// Stage 1: take sign and magnitude
	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			neg_s1 <= int_value[31];
			mag_s1 <= int_value[31] ? (~int_value + 32'd1) : int_value;
		end
	end

	// Stage 2: find the leading one
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			neg_s2  <= neg_s1;
			zero_s2 <= (mag_s1 == '0);
			mag_s2  <= mag_s1;
			lead_s2 <= i2f_pkg::find_lead(mag_s1);
		end
	end

	// Stage 3: move the leading one to the top bit and form the biased exponent
	always_ff @(posedge clk) begin
		if (rdy_s3 && v_s2) begin
			neg_s3  <= neg_s2;
			zero_s3 <= zero_s2;
			norm_s3 <= mag_s2 << (5'd31 - lead_s2);
			exp_s3  <= i2f_pkg::exp_t'(lead_s2) + i2f_pkg::ExpBias;
		end
	end

	// Round to nearest even; a carry out of the significand bumps the exponent
	always_comb begin
		sig        = norm_s3[31:8];
		guard_bit  = norm_s3[7];
		sticky_bit = |norm_s3[6:0];
		round_up   = guard_bit && (sticky_bit || sig[0]);
		sig_sum    = {1'b0, sig} + {{i2f_pkg::FracBits+1{1'b0}}, round_up};
		if (sig_sum[i2f_pkg::FracBits+1]) begin
			exp_fin  = exp_s3 + 8'd1;
			frac_fin = '0;
		end else begin
			exp_fin  = exp_s3;
			frac_fin = sig_sum[i2f_pkg::FracBits-1:0];
		end
		if (zero_s3) begin
			res_next = '0;
		end else begin
			res_next = {neg_s3, exp_fin, frac_fin};
		end
	end

	// Stage 4: hold the packed result for the output
	always_ff @(posedge clk) begin
		if (rdy_s4 && v_s3) begin
			res_s4 <= res_next;
		end
	end

	assign out_valid  = v_s4;
	assign float_bits = res_s4;

	// A nonzero result has an exponent between 2^0 and 2^31
	`I2F_ASSERT(a_exp_range, out_valid && float_bits != '0 |-> (float_bits[30:23] - 8'd127) <= 8'd31)
	// Never produce negative zero
	`I2F_ASSERT(a_no_neg_zero, out_valid && float_bits[31] |-> (float_bits[30:0] != '0))
	// The leading-one search points at a set bit of the magnitude
	`I2F_ASSERT(a_lead_set, v_s2 && !zero_s2 |-> mag_s2[lead_s2])
	// Reset empties the output stage by the following edge
	`I2F_ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !out_valid)

endmodule

// ----- tb/int32_to_float32_converter_tb.sv -----
// Testbench for the signed 32-bit integer to single-precision converter.
module int32_to_float32_converter_tb;

	typedef struct {
		i2f_pkg::word_t operand;
		i2f_pkg::word_t bits;
	} float_expect_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic signed [31:0]  int_value = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic        [31:0]  float_bits;

	float_expect_t pending_floats[$];
	int            mismatch_count = 0;
	int            burst_left = 0;
	int            stall_phase = 0;
	int            stall_mode = 0;

	int32_to_float32_converter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.int_value  (int_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.float_bits (float_bits)
	);

	always #4 clk = ~clk;

	// Round the magnitude to 24 significant bits, nearest even, and pack.
	function automatic i2f_pkg::word_t int_to_single(input i2f_pkg::word_t raw);
		logic           neg;
		i2f_pkg::word_t mag;
		i2f_pkg::word_t sig;
		i2f_pkg::exp_t  expo;
		int             lead;
		int             sh;
		logic           guard;
		logic           sticky;
		if (raw == '0) begin
			return '0;
		end
		neg  = raw[31];
		mag  = neg ? (~raw + 32'd1) : raw;
		lead = 0;
		for (int i = 31; i >= 0; i--) begin
			if (mag[i] && lead == 0) begin
				lead = i;
			end
		end
		expo = i2f_pkg::ExpBias + i2f_pkg::exp_t'(lead);
		if (lead <= i2f_pkg::FracBits) begin
			sig = mag << (i2f_pkg::FracBits - lead);
		end else begin
			sh     = lead - i2f_pkg::FracBits;
			guard  = mag[sh-1];
			sticky = |(mag & ((32'd1 << (sh - 1)) - 32'd1));
			sig    = mag >> sh;
			if (guard && (sticky || sig[0])) begin
				sig = sig + 32'd1;
			end
			// Carry out of the significand bumps the exponent
			if (sig[i2f_pkg::FracBits+1]) begin
				sig  = sig >> 1;
				expo = expo + 8'd1;
			end
		end
		return {neg, expo, sig[i2f_pkg::FracBits-1:0]};
	endfunction

	// Drive one operand and hold it until the transaction completes.
	task automatic send_int(input i2f_pkg::word_t v);
		int   gap;
		logic done;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap        = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		int_value <= v;
		do begin
			@(negedge clk);
			done = in_valid && in_ready;
			@(posedge clk);
		end while (!done);
	endtask

	// Record accepted operands and check each result against the oldest prediction.
	always @(negedge clk) begin
		float_expect_t exp_item;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				exp_item.operand = int_value;
				exp_item.bits    = int_to_single(int_value);
				pending_floats.push_back(exp_item);
			end
			if (out_valid && out_ready) begin
				if (pending_floats.size() == 0) begin
					$display("%0t: unexpected float_bits: expected none, actual %h",
						$time, float_bits);
					mismatch_count++;
				end else begin
					exp_item = pending_floats.pop_front();
					if (float_bits !== exp_item.bits) begin
						$display("%0t: float_bits for int_value %h: expected %h, actual %h",
							$time, exp_item.operand, exp_item.bits, float_bits);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Stall the result side: switch between free flow, light and heavy stalls.
	always @(posedge clk) begin
		if (stall_phase == 0) begin
			stall_phase = $urandom_range(16, 96);
			stall_mode  = $urandom_range(0, 2);
		end
		stall_phase--;
		case (stall_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				out_ready <= ($urandom_range(0, 3) == 0);
			end
		endcase
	end

	// Zero, unit values, the ends of the integer range, the edges of exact 24-bit values and alternating bit patterns.
	task automatic test_range_edges();
		send_int(32'h0000_0000);
		send_int(32'h0000_0001);
		send_int(32'hffff_ffff);
		send_int(32'h7fff_ffff);
		send_int(32'h8000_0000);
		send_int(32'h8000_0001);
		send_int(32'h0080_0000);
		send_int(32'h00ff_ffff);
		send_int(32'h5555_5555);
		send_int(32'haaaa_aaaa);
	endtask

	// Ties, sticky bits and the carry out of the significand.
	task automatic test_rounding_cases();
		send_int(32'h0100_0000);
		send_int(32'h0100_0001);
		send_int(32'h0100_0003);
		send_int(32'h0200_0003);
		send_int(32'h0200_0005);
		send_int(32'h01ff_ffff);
		send_int(32'hfe00_0001);
		send_int(32'hfeff_ffff);
		send_int(32'h7fff_ff80);
		send_int(32'h7fff_ffc0);
		send_int(32'h4000_0040);
		send_int(32'h4000_00c0);
	endtask

	// Mix full-range words, small magnitudes, near-ties and neighbors of powers of two.
	task automatic test_random_values(input int count);
		i2f_pkg::word_t v;
		int             lead;
		int             sh;
		i2f_pkg::word_t half;
		for (int n = 0; n < count; n++) begin
			case ($urandom_range(0, 3))
				0: begin
					v = $urandom;
				end
				1: begin
					v = $urandom >> $urandom_range(8, 31);
					if ($urandom_range(0, 1)) begin
						v = -v;
					end
				end
				2: begin
					lead = $urandom_range(24, 31);
					sh   = lead - i2f_pkg::FracBits;
					half = 32'd1 << (sh - 1);
					v    = (32'd1 << lead) | ($urandom & ((32'd1 << lead) - 32'd1));
					v    = v & ~((32'd1 << sh) - 32'd1);
					case ($urandom_range(0, 3))
						0: v = v | half;
						1: v = v | (half - 32'd1);
						2: v = v | (half + 32'd1);
						default: v = v | ((32'd1 << sh) - 32'd1);
					endcase
					if ($urandom_range(0, 1)) begin
						v = -v;
					end
				end
				default: begin
					v = (32'd1 << $urandom_range(0, 31))
						+ i2f_pkg::word_t'($urandom_range(0, 4)) - 32'd2;
				end
			endcase
			send_int(v);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_range_edges();
		test_rounding_cases();
		test_random_values(930);
		in_valid <= 1'b0;
		// Drain the pipeline, then watch for stray results
		while (pending_floats.size() != 0) begin
			@(posedge clk);
		end
		repeat (12) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// End a hung run
	initial begin
		#2000000;
		$display("simulation failed");
		$finish;
	end

endmodule
